@@ src/smf_pkg.sv @@
package smf_pkg;

  localparam int MAX_WINDOW  = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 4;
  localparam int CNTW        = $clog2(MAX_WINDOW + 1);
  localparam int WIDX        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMPW        = (CNTW > CFG_W) ? CNTW : CFG_W;
  localparam int APB_AW      = 2;
  localparam int APB_DW      = 32;

  localparam logic [APB_AW-1:0] ADDR_WINDOW_SIZE = '0;
  localparam logic [CFG_W-1:0]  WINDOW_RESET     = CFG_W'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNTW-1:0]               cnt_t;
  typedef logic [WIDX-1:0]               idx_t;
  typedef logic [CFG_W-1:0]              win_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_EMIT
  } smf_state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
    cnt_t win;
    idx_t half;
  } cell_ctrl_t;

  typedef struct packed {
    sample_t val;
    idx_t    idx;
    logic    ok;
  } probe_t;

endpackage

@@ src/smf_in_if.sv @@
interface smf_in_if;
  import smf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);

endinterface

@@ src/smf_out_if.sv @@
interface smf_out_if;
  import smf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t value;
  logic    end_of_sequence;
  logic    window_error;

  modport source (output valid, output value, output end_of_sequence, output window_error,
                  input ready);
  modport sink (input valid, input value, input end_of_sequence, input window_error,
                output ready);

endinterface

@@ src/smf_cell.sv @@
module smf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  smf_pkg::idx_t       cell_idx,
  input  smf_pkg::cell_ctrl_t ctrl,
  input  smf_pkg::sample_t    shift_in,
  input  smf_pkg::probe_t     probe_in,
  output smf_pkg::sample_t    data,
  output smf_pkg::probe_t     probe_out,
  output logic                is_med
);
  import smf_pkg::*;

  sample_t data_r, data_nxt;
  probe_t  probe_r, probe_nxt;
  idx_t    rank_r, rank_nxt;
  logic    own_ok;
  logic    below;

  assign own_ok = cnt_t'(cell_idx) < ctrl.win;

  // A probe ranks below this cell when smaller, or equal and from a newer position.
  assign below = probe_in.ok &&
                 (($signed(probe_in.val) < $signed(data_r)) ||
                  (($signed(probe_in.val) == $signed(data_r)) && (probe_in.idx < cell_idx)));

  always_comb begin
    data_nxt  = data_r;
    probe_nxt = probe_r;
    rank_nxt  = rank_r;
    if (ctrl.shift) begin
      data_nxt = shift_in;
    end
    if (ctrl.load) begin
      probe_nxt.val = data_r;
      probe_nxt.idx = cell_idx;
      probe_nxt.ok  = own_ok;
      rank_nxt      = '0;
    end else if (ctrl.rotate) begin
      probe_nxt = probe_in;
      if (below) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r  <= '0;
      probe_r <= '0;
      rank_r  <= '0;
    end else begin
      data_r  <= data_nxt;
      probe_r <= probe_nxt;
      rank_r  <= rank_nxt;
    end
  end

  assign data      = data_r;
  assign probe_out = probe_r;
  assign is_med    = own_ok && (rank_r == ctrl.half);

endmodule

@@ src/smf_chain.sv @@
module smf_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  smf_pkg::cell_ctrl_t ctrl,
  input  smf_pkg::sample_t    new_sample,
  output smf_pkg::sample_t    taps [smf_pkg::MAX_WINDOW],
  output smf_pkg::sample_t    median
);
  import smf_pkg::*;

  sample_t                data_w  [MAX_WINDOW];
  probe_t                 probe_w [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  med_hit;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    sample_t sh_in;
    if (g == 0) begin : g_head
      assign sh_in = new_sample;
    end else begin : g_body
      assign sh_in = data_w[g-1];
    end

    smf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (idx_t'(g)),
      .ctrl      (ctrl),
      .shift_in  (sh_in),
      .probe_in  (probe_w[(g + MAX_WINDOW - 1) % MAX_WINDOW]),
      .data      (data_w[g]),
      .probe_out (probe_w[g]),
      .is_med    (med_hit[g])
    );

    assign taps[g] = data_w[g];
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (med_hit[i]) begin
        median = median | data_w[i];
      end
    end
  end

endmodule

@@ src/sliding_median_filter_core.sv @@
// Sliding median filter over a stream of signed 16-bit words. Samples enter a shift line
// of 15 cells; a word that needs a median starts a ranking pass in which every cell's
// sample travels once round the ring of cells, each cell counting the smaller samples of
// the window, so such a word holds the block through acceptance, ranking and its first
// result. A word with a raw sample as result holds it until that result, a word with none
// does not hold it. A sequence's last word flushes up to h+1 results, one per cycle unless
// the output stalls, after a ranking pass where the median is due. Input is refused while
// a word is in work; the output register lets the next word in while a result waits.
module sliding_median_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  smf_in_if.sink                        in_ch,
  smf_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [smf_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [smf_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [smf_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import smf_pkg::*;

  smf_state_t state_r, state_nxt;
  win_cfg_t   win_r, win_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       c_r, c_nxt;
  logic       last_r, last_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       rot_r, rot_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    out_value_r, out_value_nxt;
  logic       out_eos_r, out_eos_nxt;
  logic       out_err_r, out_err_nxt;

  cell_ctrl_t ctrl;
  sample_t    taps [MAX_WINDOW];
  sample_t    median;

  logic       accept;
  logic       cfg_write;
  logic [CMPW-1:0] win_ext;
  cnt_t       win_eff;
  cnt_t       half;
  logic       odd;
  cnt_t       c_inc;
  cnt_t       top;
  logic       need_out;
  logic       need_med;
  idx_t       start_idx;
  logic       emit_ok;
  logic       emit_done;
  logic       use_med;
  logic       rot_done;

  assign accept    = in_ch.valid && in_ch.ready;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_WINDOW_SIZE);

  assign win_ext = CMPW'(win_r);
  assign win_eff = CNTW'((win_ext > CMPW'(MAX_WINDOW)) ? CMPW'(MAX_WINDOW) : win_ext);
  assign half    = (win_eff - 1'b1) >> 1;
  assign odd     = win_eff[0];

  assign c_inc     = (cnt_r == CNTW'(MAX_WINDOW)) ? cnt_r : cnt_r + 1'b1;
  assign top       = ((c_inc - 1'b1) < half) ? (c_inc - 1'b1) : half;
  assign need_out  = in_ch.last_sample || (odd && (c_inc > half));
  assign need_med  = odd && (c_inc >= win_eff);
  assign start_idx = !odd ? '0 : (in_ch.last_sample ? idx_t'(top) : idx_t'(half));

  assign emit_ok   = !out_valid_r || out_ch.ready;
  assign emit_done = !last_r || (idx_r == '0);
  assign use_med   = (cnt_t'(idx_r) == half) && (c_r >= win_eff);
  assign rot_done  = (rot_r == idx_t'(MAX_WINDOW - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && need_out) begin
          state_nxt = need_med ? ST_RANK : ST_EMIT;
        end
      end
      ST_RANK: begin
        if (rot_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok && emit_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    rot_nxt       = '0;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_eos_nxt   = out_eos_r;
    out_err_nxt   = out_err_r;

    ctrl.shift  = accept;
    ctrl.load   = (state_r == ST_RANK) && (rot_r == '0);
    ctrl.rotate = (state_r == ST_RANK) && (rot_r != '0);
    ctrl.win    = win_eff;
    ctrl.half   = idx_t'(half);

    if (cfg_write) begin
      win_nxt = cfg_pwdata[CFG_W-1:0];
    end

    if (accept) begin
      cnt_nxt  = in_ch.last_sample ? '0 : c_inc;
      c_nxt    = c_inc;
      last_nxt = in_ch.last_sample;
      idx_nxt  = start_idx;
    end

    if ((state_r == ST_RANK) && !rot_done) begin
      rot_nxt = rot_r + 1'b1;
    end

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if ((state_r == ST_EMIT) && emit_ok) begin
      out_valid_nxt = 1'b1;
      out_err_nxt   = !odd;
      out_eos_nxt   = last_r && (idx_r == '0);
      if (!odd) begin
        out_value_nxt = '0;
      end else if (use_med) begin
        out_value_nxt = median;
      end else begin
        out_value_nxt = taps[idx_r];
      end
      if (!emit_done) begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WINDOW_RESET;
      cnt_r       <= '0;
      c_r         <= '0;
      last_r      <= 1'b0;
      idx_r       <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      cnt_r       <= cnt_nxt;
      c_r         <= c_nxt;
      last_r      <= last_nxt;
      idx_r       <= idx_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_eos_r   <= out_eos_nxt;
    out_err_r   <= out_err_nxt;
  end

  smf_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .new_sample (in_ch.sample),
    .taps       (taps),
    .median     (median)
  );

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.value           = out_value_r;
  assign out_ch.end_of_sequence = out_eos_r;
  assign out_ch.window_error    = out_err_r;

  assign cfg_prdata = (cfg_paddr == ADDR_WINDOW_SIZE) ? APB_DW'(win_r) : '0;
  assign cfg_pready = 1'b1;

endmodule

@@ src/smf_checker.sv @@
module smf_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input smf_pkg::sample_t out_value,
  input logic             out_eos,
  input logic             out_err
);
  import smf_pkg::*;

  // A stalled word keeps its place and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_eos) &&
                                $stable(out_err))
    else $error("stalled output word changed");

  // The last word of a sequence always yields at least one result, so input must close.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after the last word of a sequence");

  // An error word closes the sequence and carries a zero value.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_eos && (out_value == '0))
    else $error("malformed window error word");

endmodule

bind sliding_median_filter_core smf_checker u_smf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_sample),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .out_eos   (out_ch.end_of_sequence),
  .out_err   (out_ch.window_error)
);
